FILE: src/hfsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hfsa_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int SLOT_W    = 7;
   localparam int COUNT_W   = 7;

   localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = SLOT_W'(MAX_SLOTS);

   typedef struct packed {
      logic                granted;
      logic [SLOT_W-1:0]   slot;
      logic [COUNT_W-1:0]  grant_total;
      logic                halted;
   } hfsa_result_type;

endpackage

`default_nettype wire

FILE: src/hfsa_search.sv
`timescale 1ns / 1ps
`default_nettype none

module hfsa_search (
   input  wire logic [hfsa_pkg::MAX_SLOTS-1:0] free_map,
   input  wire logic [hfsa_pkg::SLOT_W-1:0]    limit,
   input  wire logic [hfsa_pkg::SLOT_W-1:0]    slot_count,
   output logic                                found,
   output logic [hfsa_pkg::IDX_W-1:0]          found_idx
);

   localparam int TOP_W = $clog2(hfsa_pkg::MAX_SLOTS + 1) > hfsa_pkg::SLOT_W ?
                          $clog2(hfsa_pkg::MAX_SLOTS + 1) : hfsa_pkg::SLOT_W;

   logic [TOP_W-1:0]                 top;
   logic [hfsa_pkg::MAX_SLOTS-1:0]   candidates;

   // Highest usable slot is the least of the limit, the slot count and the map size.
   always_comb begin
      top = TOP_W'(limit);
      if (TOP_W'(slot_count) < top) begin
         top = TOP_W'(slot_count);
      end
      if (TOP_W'(hfsa_pkg::MAX_SLOTS) < top) begin
         top = TOP_W'(hfsa_pkg::MAX_SLOTS);
      end
   end

   // Bit i stands for slot i+1, so it qualifies when i is below top.
   always_comb begin
      for (int i = 0; i < hfsa_pkg::MAX_SLOTS; i++) begin
         candidates[i] = free_map[i] && (TOP_W'(i) < top);
      end
   end

   always_comb begin
      found_idx = '0;
      for (int i = 0; i < hfsa_pkg::MAX_SLOTS; i++) begin
         if (candidates[i]) begin
            found_idx = hfsa_pkg::IDX_W'(i);
         end
      end
      found = |candidates;
   end

endmodule

`default_nettype wire

FILE: src/hfsa_state.sv
`timescale 1ns / 1ps
`default_nettype none

module hfsa_state (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [hfsa_pkg::SLOT_W-1:0]   limit,
   input  wire logic [hfsa_pkg::SLOT_W-1:0]   slot_count,
   output hfsa_pkg::hfsa_result_type          result
);

   logic [hfsa_pkg::MAX_SLOTS-1:0] free_map_ff, free_map_in;
   logic [hfsa_pkg::COUNT_W-1:0]   grant_count_ff, grant_count_in;
   logic                           stopped_ff, stopped_in;
   logic                           found;
   logic [hfsa_pkg::IDX_W-1:0]     found_idx;
   logic                           grant;

   hfsa_search u_search (
      .free_map   (free_map_ff),
      .limit      (limit),
      .slot_count (slot_count),
      .found      (found),
      .found_idx  (found_idx)
   );

   assign grant = !stopped_ff && found;

   always_comb begin
      free_map_in    = free_map_ff;
      grant_count_in = grant_count_ff;
      stopped_in     = stopped_ff;
      if (step && grant) begin
         free_map_in[found_idx] = 1'b0;
         grant_count_in         = grant_count_ff + 1'b1;
      end else if (step) begin
         stopped_in = 1'b1;
      end
   end

   always_comb begin
      result.granted     = grant;
      result.slot        = grant ? hfsa_pkg::SLOT_W'(found_idx) + 1'b1 : '0;
      result.grant_total = grant ? grant_count_ff + 1'b1 : grant_count_ff;
      result.halted      = !grant;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff    <= '1;
         grant_count_ff <= '0;
         stopped_ff     <= 1'b0;
      end else begin
         free_map_ff    <= free_map_in;
         grant_count_ff <= grant_count_in;
         stopped_ff     <= stopped_in;
      end
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halted flag cleared without reset");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      step && grant |=> grant_count_ff == $past(grant_count_ff) + 1'b1)
      else $error("grant count did not advance on a grant");

   a_slot_taken: assert property (@(posedge clock) disable iff (reset)
      step && grant |=> !free_map_ff[$past(found_idx)])
      else $error("granted slot still marked free");

   a_no_grant_halted: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !result.granted && result.slot == '0)
      else $error("grant issued while halted");

endmodule

`default_nettype wire

FILE: src/highest_free_slot_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Highest-free-slot allocator. Each request names a limit; the unit grants
// the highest free slot numbered at or below both the limit and the slot
// count held in the configuration register, marks it taken and reports the
// running grant total. The first request that finds no slot latches the
// halted flag, and every later request is refused until reset. One request
// is accepted per clock while rsp_tready lets responses drain: the request
// is captured in an input register, and a single pass of masking
// and priority encoding over the 64-slot free map feeds the response
// register. Write the slot count only while no request is in flight.

module highest_free_slot_allocator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data,   // slot_count
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [6:0] limit, [7] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata      // [0] granted, [7:1] slot,
                                           // [14:8] grant_total, [15] halted
);

   logic                            in_valid_ff, in_valid_in;
   logic [hfsa_pkg::SLOT_W-1:0]     limit_ff, limit_in;
   logic                            out_valid_ff, out_valid_in;
   hfsa_pkg::hfsa_result_type       out_ff, out_in;
   logic [hfsa_pkg::SLOT_W-1:0]     slot_count_ff, slot_count_in;
   hfsa_pkg::hfsa_result_type       result;
   logic                            advance;

   // The held request moves on whenever the response register is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   hfsa_state u_state (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .limit      (limit_ff),
      .slot_count (slot_count_ff),
      .result     (result)
   );

   always_comb begin
      slot_count_in = csr_wr_en ? csr_wr_data : slot_count_ff;
      in_valid_in   = req_tvalid && req_tready ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      limit_in      = req_tvalid && req_tready ? req_tdata[hfsa_pkg::SLOT_W-1:0] : limit_ff;
      out_in        = advance ? result : out_ff;
      out_valid_in  = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         slot_count_ff <= hfsa_pkg::SLOT_COUNT_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         slot_count_ff <= slot_count_in;
      end
      limit_ff <= limit_in;
      out_ff   <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.halted, out_ff.grant_total, out_ff.slot, out_ff.granted};

endmodule

`default_nettype wire

FILE: tb/highest_free_slot_allocator_unit_tb.sv
`timescale 1ns / 1ps

module highest_free_slot_allocator_unit_tb;

   localparam int QUIET_LIMIT = 2000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // Tracks the free map, grant count and halted flag, and holds the responses that the
   // accepted requests still owe.
   class slot_ledger_type;
      logic [hfsa_pkg::MAX_SLOTS-1:0] free_map    = '1;
      logic [hfsa_pkg::COUNT_W-1:0]   grant_count = '0;
      logic                           halted      = 1'b0;
      logic [hfsa_pkg::SLOT_W-1:0]    slot_count  = hfsa_pkg::SLOT_COUNT_RESET;
      hfsa_pkg::hfsa_result_type      owed[$];
      int                             failures    = 0;

      function void set_slot_count(logic [hfsa_pkg::SLOT_W-1:0] value);
         slot_count = value;
      endfunction

      // Lowest free slot number, or MAX_SLOTS + 1 when every slot is taken.
      function int first_free();
         for (int n = 1; n <= hfsa_pkg::MAX_SLOTS; n++)
            if (free_map[n-1]) return n;
         return hfsa_pkg::MAX_SLOTS + 1;
      endfunction

      function void note_request(logic [hfsa_pkg::SLOT_W-1:0] limit);
         int                        top;
         int                        found;
         hfsa_pkg::hfsa_result_type want;
         top = limit;
         if (top > slot_count) top = slot_count;
         if (top > hfsa_pkg::MAX_SLOTS) top = hfsa_pkg::MAX_SLOTS;
         found = 0;
         if (!halted) begin
            for (int n = top; n >= 1 && found == 0; n--)
               if (free_map[n-1]) found = n;
            if (found != 0) begin
               free_map[found-1] = 1'b0;
               grant_count = grant_count + 1'b1;
            end else begin
               halted = 1'b1;
            end
         end
         want.granted     = (found != 0);
         want.slot        = hfsa_pkg::SLOT_W'(found);
         want.grant_total = grant_count;
         want.halted      = halted;
         owed.push_back(want);
      endfunction

      function void check_response(logic [15:0] data);
         hfsa_pkg::hfsa_result_type got;
         hfsa_pkg::hfsa_result_type want;
         got.granted     = data[0];
         got.slot        = data[7:1];
         got.grant_total = data[14:8];
         got.halted      = data[15];
         if (owed.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("response %h arrived with no request outstanding", data);
            return;
         end
         want = owed.pop_front();
         if (got.granted !== want.granted || got.slot !== want.slot ||
             got.grant_total !== want.grant_total || got.halted !== want.halted) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: want g=%0d slot=%0d total=%0d halt=%0d, got %0d %0d %0d %0d",
                        want.granted, want.slot, want.grant_total, want.halted,
                        got.granted, got.slot, got.grant_total, got.halted);
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [6:0]  csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [6:0] limit, [7] zero
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [0] granted, [7:1] slot, [14:8] grant_total, [15] halted

   slot_ledger_type ledger = new;
   int              send_gap_pct = 0;
   int              stall_pct    = 0;
   int              quiet        = 0;

   highest_free_slot_allocator_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) ledger.set_slot_count(csr_wr_data);
         if (req_tvalid && req_tready) ledger.note_request(req_tdata[6:0]);
         if (rsp_tvalid && rsp_tready) ledger.check_response(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet + 1 >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      send_gap_pct = (mode == IDLE_SENDER || mode == IDLE_NONE) ? 0 : 9;
      stall_pct    = (mode == IDLE_RECEIVER || mode == IDLE_NONE) ? 0 : 9;
      if (mode == IDLE_SENDER) send_gap_pct = 62;
      if (mode == IDLE_RECEIVER) stall_pct = 62;
   endtask

   // Called at a falling edge; returns at the falling edge after the request is taken,
   // with tvalid still high so that back-to-back requests need no extra assignment.
   task automatic send_request(input logic [6:0] limit);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, limit};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (ledger.owed.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_slot_count(input logic [6:0] value);
      wait_for_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int          mode;
      int          lo;
      int          reach;
      int          burst;
      int          count_pick;
      logic [6:0]  limit;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, all grants: limits above the count, at the edges of the map, and
      // slot counts above the map size, just above it, and small.
      set_idle(IDLE_NONE);
      send_request(7'd127);
      send_request(7'd64);
      send_request(7'd65);
      send_request(7'd1);
      send_request(7'd63);
      send_request(7'd2);
      write_slot_count(7'd127);
      send_request(7'd127);
      send_request(7'd100);
      write_slot_count(7'd65);
      send_request(7'd70);
      write_slot_count(7'd5);
      send_request(7'd127);
      send_request(7'd5);
      send_request(7'd4);
      write_slot_count(7'd10);
      send_request(7'd10);
      send_request(7'd7);
      send_request(7'd9);
      send_request(7'd8);
      send_request(7'd6);
      write_slot_count(7'd64);
      send_request(7'd32);
      send_request(7'd33);
      send_request(7'd16);

      // Random grants until the map is empty. Every slot count and limit is drawn at or
      // above the lowest free slot, so each request is granted.
      mode = 0;
      while (ledger.first_free() <= hfsa_pkg::MAX_SLOTS) begin
         set_idle(idle_mode_type'(mode % 4));
         mode++;
         lo = ledger.first_free();
         case ($urandom_range(3))
            0: count_pick = hfsa_pkg::MAX_SLOTS;
            1: count_pick = 127;
            2: count_pick = lo;
            default: count_pick = $urandom_range(lo, 127);
         endcase
         write_slot_count(7'(count_pick));
         reach = (count_pick > hfsa_pkg::MAX_SLOTS) ? hfsa_pkg::MAX_SLOTS : count_pick;
         burst = $urandom_range(4, 14);
         while (burst > 0 && ledger.first_free() <= reach) begin
            lo = ledger.first_free();
            if ($urandom_range(1) == 0) limit = 7'($urandom_range(lo, reach));
            else limit = 7'($urandom_range(lo, 127));
            send_request(limit);
            burst--;
         end
      end

      // With every slot taken this request halts the allocator.
      write_slot_count(7'd64);
      send_request(7'($urandom_range(1, 127)));

      // Halted: every request is refused, whatever the limit or slot count.
      for (int p = 0; p < 8; p++) begin
         set_idle(idle_mode_type'(p % 4));
         case (p)
            0: write_slot_count(7'd0);
            1: write_slot_count(7'd1);
            2: write_slot_count(7'd127);
            default: write_slot_count(7'($urandom_range(127)));
         endcase
         repeat (75) begin
            if ($urandom_range(9) == 0) limit = 7'd0;
            else limit = 7'($urandom_range(127));
            send_request(limit);
         end
      end

      wait_for_responses();
      repeat (8) @(negedge clock);
      if (ledger.failures == 0 && ledger.owed.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: highest_free_slot_allocator_unit.f
src/hfsa_pkg.sv
src/hfsa_search.sv
src/hfsa_state.sv
src/highest_free_slot_allocator_unit.sv
tb/highest_free_slot_allocator_unit_tb.sv
